[rtl/core/erpa_pkg.sv]
// shared types and constants for the echo range proximity alarm
package erpa_pkg;

   localparam int unsigned CapW   = 16;
   localparam int unsigned DistW  = 13;
   localparam int unsigned TickW  = 4;
   localparam int unsigned BlinkW = 3;
   localparam int unsigned CsrAddrW = 2;
   localparam int unsigned CsrDataW = 13;
   localparam int unsigned ReqDataW = 16;
   localparam int unsigned RspDataW = 16;

   localparam logic [CsrAddrW-1:0] CSR_VALID_LIMIT = 2'd0;
   localparam logic [CsrAddrW-1:0] CSR_WARN_LIMIT  = 2'd1;
   localparam logic [CsrAddrW-1:0] CSR_TICKS       = 2'd2;

   localparam logic [DistW-1:0] VALID_LIMIT_RST = 13'd3800;
   localparam logic [DistW-1:0] WARN_LIMIT_RST  = 13'd400;
   localparam logic [TickW-1:0] TICKS_RST       = 4'd5;

   localparam logic FUNC_EDGE = 1'b0;
   localparam logic FUNC_TICK = 1'b1;

   // floor(h * 17 / 100) == (h * RANGE_RECIP) >> RANGE_SHIFT for h < 2^17
   localparam int unsigned RecipW      = 18;
   localparam int unsigned RANGE_SHIFT = 20;
   localparam logic [RecipW-1:0] RANGE_RECIP = 18'd178258;
   localparam int unsigned ProdW = CapW - 1 + RecipW;

   localparam logic [DistW-1:0] BAND_1 = 13'd100;
   localparam logic [DistW-1:0] BAND_2 = 13'd200;
   localparam logic [DistW-1:0] BAND_3 = 13'd300;

   typedef struct packed {
      logic [BlinkW-1:0] blink;
      logic              level;
   } alarm_state_type;

endpackage

[rtl/core/echo_range_proximity_alarm.sv]
// top level: request stage, state update and response register
//
// Usage:
//   Requests arrive on req_ (tuser = event kind, 0 echo edge, 1 timer tick;
//   tdata = capture count). Echo edges alternate start/end; an end edge
//   turns the echo width into millimetres and keeps it when it is within
//   the validity limit. Every ticks_per_period-th tick raises the trigger
//   flag and runs the blinking alarm step.
//   Every request gives one response on rsp_ with the held distance, the
//   trigger flag and the alarm level.
//   Flow: a taken request is registered in the request stage; it updates
//   the state and is written into the response register when that stage
//   advances, i.e. when the response register is empty or rsp_tready is high.
//   Throughput: one request per cycle while rsp_tready stays high; the
//   update through the 15x18 conversion multiplier is combinational.
//   Stall: when rsp_tready is low the response register holds, one more
//   request is still taken into the request stage, then req_tready drops.
//   Reset clears the valid flags and the echo, tick and alarm state and loads the register defaults (3800, 400, 5).
//   csr_ writes take effect at once and are meant for idle periods.
module echo_range_proximity_alarm (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [erpa_pkg::ReqDataW-1:0] req_tdata,  // [15:0] capture_count
   input  logic                          req_tuser,  // [0] func
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [erpa_pkg::RspDataW-1:0] rsp_tdata,  // [12:0] distance_mm, [13] trigger_pulse,
                                                     // [14] alarm_on, [15] zero
   input  logic                          csr_we,
   input  logic [erpa_pkg::CsrAddrW-1:0] csr_addr,
   input  logic [erpa_pkg::CsrDataW-1:0] csr_wdata
);
   import erpa_pkg::*;

   logic [DistW-1:0] valid_limit_ff, valid_limit_in;
   logic [DistW-1:0] warn_limit_ff,  warn_limit_in;
   logic [TickW-1:0] ticks_ff,       ticks_in;

   logic             s1_valid_ff, s1_valid_in;
   logic             s1_func_ff,  s1_func_in;
   logic [CapW-1:0]  s1_cap_ff,   s1_cap_in;

   logic             phase_ff,    phase_in;
   logic [CapW-1:0]  start_ff,    start_in;
   logic [DistW-1:0] held_ff,     held_in;
   logic [TickW-1:0] tick_ff,     tick_in;
   alarm_state_type  alarm_ff,    alarm_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [RspDataW-1:0] rsp_data_ff,  rsp_data_in;

   logic             req_take;
   logic             s1_adv;
   logic [DistW-1:0] dist_mm;
   logic             dist_ok;
   logic [TickW-1:0] tick_inc;
   logic             trig;
   alarm_state_type  alarm_step;

   erpa_range u_range (
      .cap         (s1_cap_ff),
      .start       (start_ff),
      .valid_limit (valid_limit_ff),
      .dist_mm     (dist_mm),
      .dist_ok     (dist_ok)
   );

   erpa_alarm u_alarm (
      .held       (held_ff),
      .warn_limit (warn_limit_ff),
      .cur        (alarm_ff),
      .nxt        (alarm_step)
   );

   assign s1_adv     = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_adv;
   assign req_take   = req_tvalid && req_tready;
   assign tick_inc   = tick_ff + 4'd1;
   assign trig       = (s1_func_ff == FUNC_TICK) && (tick_inc == ticks_ff);

   always_comb begin
      valid_limit_in = valid_limit_ff;
      warn_limit_in  = warn_limit_ff;
      ticks_in       = ticks_ff;
      if (csr_we) begin
         unique case (csr_addr)
            CSR_VALID_LIMIT: valid_limit_in = csr_wdata;
            CSR_WARN_LIMIT:  warn_limit_in  = csr_wdata;
            CSR_TICKS:       ticks_in       = csr_wdata[TickW-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_func_in  = s1_func_ff;
      s1_cap_in   = s1_cap_ff;
      if (req_take) begin
         s1_valid_in = 1'b1;
         s1_func_in  = req_tuser;
         s1_cap_in   = req_tdata[CapW-1:0];
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      phase_in = phase_ff;
      start_in = start_ff;
      held_in  = held_ff;
      tick_in  = tick_ff;
      alarm_in = alarm_ff;
      if (s1_adv) begin
         if (s1_func_ff == FUNC_EDGE) begin
            phase_in = ~phase_ff;
            if (!phase_ff) begin
               start_in = s1_cap_ff;
            end else if (dist_ok) begin
               held_in = dist_mm;
            end
         end else begin
            tick_in = trig ? '0 : tick_inc;
            if (trig) begin
               alarm_in = alarm_step;
            end
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (s1_adv) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {1'b0, alarm_in.level, trig, held_in};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_limit_ff <= VALID_LIMIT_RST;
         warn_limit_ff  <= WARN_LIMIT_RST;
         ticks_ff       <= TICKS_RST;
         s1_valid_ff    <= 1'b0;
         phase_ff       <= 1'b0;
         start_ff       <= '0;
         held_ff        <= '0;
         tick_ff        <= '0;
         alarm_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         valid_limit_ff <= valid_limit_in;
         warn_limit_ff  <= warn_limit_in;
         ticks_ff       <= ticks_in;
         s1_valid_ff    <= s1_valid_in;
         phase_ff       <= phase_in;
         start_ff       <= start_in;
         held_ff        <= held_in;
         tick_ff        <= tick_in;
         alarm_ff       <= alarm_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      s1_func_ff  <= s1_func_in;
      s1_cap_ff   <= s1_cap_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_blink_bound: assert property (@(posedge clock) disable iff (reset)
      alarm_ff.blink <= 3'd3)
      else $error("blink counter out of range");

   a_trig_clears_tick: assert property (@(posedge clock) disable iff (reset)
      s1_adv && trig |=> tick_ff == '0)
      else $error("tick counter not cleared on trigger");

   a_far_alarm_off: assert property (@(posedge clock) disable iff (reset)
      s1_adv && trig && (held_ff > warn_limit_ff) |=> !alarm_ff.level && rsp_tdata[14] == 1'b0)
      else $error("alarm on beyond warning limit");

   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !s1_valid_ff |-> req_tready)
      else $error("request refused with empty stage");

endmodule

[rtl/core/erpa_range.sv]
// echo width to millimetre conversion and validity check
module erpa_range (
   input  logic [erpa_pkg::CapW-1:0]  cap,
   input  logic [erpa_pkg::CapW-1:0]  start,
   input  logic [erpa_pkg::DistW-1:0] valid_limit,
   output logic [erpa_pkg::DistW-1:0] dist_mm,
   output logic                       dist_ok
);
   import erpa_pkg::*;

   logic [CapW-1:0]  width;
   logic [CapW-2:0]  half;
   logic [ProdW-1:0] prod;

   assign width   = cap - start;
   assign half    = width[CapW-1:1];
   assign prod    = ProdW'(half) * ProdW'(RANGE_RECIP);
   assign dist_mm = prod[RANGE_SHIFT +: DistW];
   assign dist_ok = (dist_mm <= valid_limit);

endmodule

[rtl/core/erpa_alarm.sv]
// warning step: blink period from distance and alarm toggle, alarm off beyond the warning limit
module erpa_alarm (
   input  logic [erpa_pkg::DistW-1:0] held,
   input  logic [erpa_pkg::DistW-1:0] warn_limit,
   input  erpa_pkg::alarm_state_type  cur,
   output erpa_pkg::alarm_state_type  nxt
);
   import erpa_pkg::*;

   logic [BlinkW-1:0] period;
   logic [BlinkW-1:0] blink_inc;

   always_comb begin
      priority if (held < BAND_1) begin
         period = 3'd1;
      end else if (held < BAND_2) begin
         period = 3'd2;
      end else if (held < BAND_3) begin
         period = 3'd3;
      end else begin
         period = 3'd4;
      end
   end

   assign blink_inc = cur.blink + 3'd1;

   always_comb begin
      nxt = cur;
      if (held <= warn_limit) begin
         if (blink_inc >= period) begin
            nxt.blink = '0;
            nxt.level = ~cur.level;
         end else begin
            nxt.blink = blink_inc;
         end
      end else begin
         nxt.level = 1'b0;
      end
   end

endmodule
